>>> hdl/velocity_pid_with_position_target_unit_defines.svh
// assertion macros shared by the velocity pid rtl
`ifndef VELOCITY_PID_WITH_POSITION_TARGET_UNIT_DEFINES_SVH
`define VELOCITY_PID_WITH_POSITION_TARGET_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define VPID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define VPID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/vpid_pkg.sv
// shared types, constants and helpers for the velocity pid block
package vpid_pkg;

    // velocity limit, pi/2 in q16.16
    localparam int VEL_LIMIT = 102944;

    localparam int DATA_W   = 32;
    localparam int DT_W     = 31;
    localparam int VEL_W    = 18;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W   = 4;

    typedef logic [STEP_W-1:0] step_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_TIME_STEP,
        REG_INV_TIME_STEP
    } cfg_reg_t;

    // multiplier operand a sources
    typedef enum logic [2:0] {
        MA_TVEL,
        MA_ERR,
        MA_ESUM,
        MA_DIFF,
        MA_T
    } mul_a_t;

    // multiplier operand b sources
    typedef enum logic [2:0] {
        MB_TS,
        MB_GP,
        MB_GI,
        MB_GD,
        MB_INV
    } mul_b_t;

    // datapath operations
    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_STEP5,
        ALU_GOAL,
        ALU_ERR,
        ALU_ESUM,
        ALU_ACC_LD,
        ALU_ACC_ADD,
        ALU_TSAT,
        ALU_CTRL,
        ALU_OUT
    } alu_op_t;

    // one microcode control word
    typedef struct packed {
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        alu_op_t alu;
        logic    diff_en;
        logic    jmp_first;
        step_t   target;
        logic    last;
    } vpid_cw_t;

    // saturate a signed 64-bit value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if ((x[63:31] == '0) || (x[63:31] == '1))
        begin
            r = x[31:0];
        end
        else if (x[63])
        begin
            r = {1'b1, 31'b0};
        end
        else
        begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> hdl/vpid_seq.sv
// microcode sequencer: step counter, control store and conditional jump
module vpid_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               first,
    input  logic               hold,
    output vpid_pkg::vpid_cw_t cw,
    output logic               busy
);
    import vpid_pkg::*;

    // control store addresses
    localparam step_t U_STEP_MUL = 4'd0;
    localparam step_t U_STEP5    = 4'd1;
    localparam step_t U_GOAL     = 4'd2;
    localparam step_t U_ERR      = 4'd3;
    localparam step_t U_ESUM_MUL = 4'd4;
    localparam step_t U_ESUM     = 4'd5;
    localparam step_t U_P_LD     = 4'd6;
    localparam step_t U_I_ADD    = 4'd7;
    localparam step_t U_DK       = 4'd8;
    localparam step_t U_D_MUL    = 4'd9;
    localparam step_t U_D_ADD    = 4'd10;
    localparam step_t U_CTRL     = 4'd11;
    localparam step_t U_OUT_MUL  = 4'd12;
    localparam step_t U_OUT      = 4'd13;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    seq_state_t state_reg;
    step_t      step_reg;
    vpid_cw_t   word;

    // control store
    function automatic vpid_cw_t ucode(input step_t s);
        vpid_cw_t w;
        w = '{mul_a: MA_T, mul_b: MB_INV, alu: ALU_NOP, diff_en: 1'b0,
              jmp_first: 1'b0, target: U_STEP_MUL, last: 1'b0};
        case (s)
            U_STEP_MUL:
            begin
                w.mul_a = MA_TVEL;
                w.mul_b = MB_TS;
            end
            U_STEP5:    w.alu = ALU_STEP5;
            U_GOAL:     w.alu = ALU_GOAL;
            U_ERR:      w.alu = ALU_ERR;
            U_ESUM_MUL:
            begin
                w.mul_a   = MA_ERR;
                w.mul_b   = MB_TS;
                w.diff_en = 1'b1;
            end
            U_ESUM:
            begin
                w.alu   = ALU_ESUM;
                w.mul_a = MA_ERR;
                w.mul_b = MB_GP;
            end
            U_P_LD:
            begin
                w.alu   = ALU_ACC_LD;
                w.mul_a = MA_ESUM;
                w.mul_b = MB_GI;
            end
            U_I_ADD:
            begin
                w.alu       = ALU_ACC_ADD;
                w.mul_a     = MA_DIFF;
                w.mul_b     = MB_GD;
                w.jmp_first = 1'b1;
                w.target    = U_CTRL;
            end
            U_DK:       w.alu = ALU_TSAT;
            U_D_MUL:
            begin
                w.mul_a = MA_T;
                w.mul_b = MB_INV;
            end
            U_D_ADD:    w.alu = ALU_ACC_ADD;
            U_CTRL:     w.alu = ALU_CTRL;
            U_OUT_MUL:
            begin
                w.mul_a = MA_T;
                w.mul_b = MB_INV;
            end
            U_OUT:
            begin
                w.alu  = ALU_OUT;
                w.last = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    assign word = ucode(step_reg);

    // only the running program drives the datapath
    always_comb
    begin
        cw = word;
        if (state_reg != SEQ_RUN)
        begin
            cw.alu     = ALU_NOP;
            cw.diff_en = 1'b0;
            cw.last    = 1'b0;
        end
    end

    assign busy = (state_reg == SEQ_RUN);

    // step counter with conditional jump
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            step_reg  <= U_STEP_MUL;
        end
        else
        begin
            case (state_reg)
                SEQ_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= SEQ_RUN;
                        step_reg  <= U_STEP_MUL;
                    end
                end
                SEQ_RUN:
                begin
                    if (!hold)
                    begin
                        if (word.last)
                        begin
                            state_reg <= SEQ_IDLE;
                        end
                        else if (word.jmp_first && first)
                        begin
                            step_reg <= word.target;
                        end
                        else
                        begin
                            step_reg <= step_reg + step_t'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= SEQ_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/velocity_pid_with_position_target_unit.sv
// Each sample runs the microcode program once; the first sample after reset skips the derivative steps.
// Samples do not overlap: a new one is taken only when the sequencer is idle, as the single shared
// multiplier is stepped through by the microcode program for each sample.
// A new sample is taken while the previous command still waits in its output register.
// Reset (rst_n low, asynchronous): gains zero, time_step and inv_time_step 1.0,
// goal, integral and last error zero, first-step flag set, no command pending.
`include "velocity_pid_with_position_target_unit_defines.svh"

// top level: pid datapath, configuration registers and handshakes
module velocity_pid_with_position_target_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [vpid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vpid_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [vpid_pkg::DATA_W-1:0]    measured_pos,
    input  logic signed [vpid_pkg::DATA_W-1:0]    target_vel,
    output logic                                  cmd_valid,
    input  logic                                  cmd_ready,
    output logic signed [vpid_pkg::VEL_W-1:0]     drive_vel,
    output logic                                  clamped
);
    import vpid_pkg::*;

    localparam int MA_W   = DATA_W + 1;
    localparam int PROD_W = MA_W + DATA_W;
    localparam int SH_W   = PROD_W - 16;
    localparam int ACC_W  = DATA_W + 2;

    localparam logic signed [SH_W-1:0]  LIM_SH = SH_W'(VEL_LIMIT);
    localparam logic signed [VEL_W-1:0] LIM_OUT = VEL_W'(VEL_LIMIT);
    localparam logic [DT_W-1:0]         DT_ONE = DT_W'(65536);

    // configuration registers
    logic signed [DATA_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DT_W-1:0]          ts_reg, inv_reg;

    // sample and working registers
    logic signed [DATA_W-1:0] meas_reg, meas_next;
    logic signed [DATA_W-1:0] tvel_reg, tvel_next;
    logic signed [DATA_W-1:0] goal_reg, goal_next;
    logic signed [DATA_W-1:0] esum_reg, esum_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic signed [DATA_W-1:0] err_reg, err_next;
    logic signed [DATA_W-1:0] t_reg, t_next;
    logic signed [MA_W-1:0]   diff_reg, diff_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     first_reg, first_next;

    // command output register
    logic signed [VEL_W-1:0]  drive_reg, drive_next;
    logic                     clamped_reg, clamped_next;
    logic                     cmd_valid_reg, cmd_valid_next;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [SH_W-1:0]   sh;
    logic signed [SH_W+2:0]   sh5;
    logic                     accept;
    logic                     hold;
    logic                     out_wr;
    logic                     busy;
    vpid_cw_t                 cw;

    // microcode sequencer
    vpid_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .first (first_reg),
        .hold  (hold),
        .cw    (cw),
        .busy  (busy)
    );

    // handshakes
    assign sample_ready = !busy;
    assign accept       = sample_valid && sample_ready;
    assign hold         = cw.last && cmd_valid_reg && !cmd_ready;
    assign out_wr       = (cw.alu == ALU_OUT) && !hold;
    assign cmd_valid    = cmd_valid_reg;
    assign drive_vel    = drive_reg;
    assign clamped      = clamped_reg;

    // multiplier operand selection
    always_comb
    begin
        case (cw.mul_a)
            MA_TVEL: mul_a = MA_W'(tvel_reg);
            MA_ERR:  mul_a = MA_W'(err_reg);
            MA_ESUM: mul_a = MA_W'(esum_reg);
            MA_DIFF: mul_a = diff_reg;
            MA_T:    mul_a = MA_W'(t_reg);
            default: mul_a = '0;
        endcase
        case (cw.mul_b)
            MB_TS:   mul_b = $signed({1'b0, ts_reg});
            MB_GP:   mul_b = gain_p_reg;
            MB_GI:   mul_b = gain_i_reg;
            MB_GD:   mul_b = gain_d_reg;
            MB_INV:  mul_b = $signed({1'b0, inv_reg});
            default: mul_b = '0;
        endcase
    end

    // product scaled back to q16.16 with floor rounding
    assign sh  = prod_reg[PROD_W-1:16];
    assign sh5 = ((SH_W+3)'(sh) <<< 2) + (SH_W+3)'(sh);

    // datapath operations
    always_comb
    begin
        meas_next      = meas_reg;
        tvel_next      = tvel_reg;
        goal_next      = goal_reg;
        esum_next      = esum_reg;
        prev_next      = prev_reg;
        err_next       = err_reg;
        t_next         = t_reg;
        diff_next      = diff_reg;
        acc_next       = acc_reg;
        first_next     = first_reg;
        drive_next     = drive_reg;
        clamped_next   = clamped_reg;
        cmd_valid_next = cmd_valid_reg;

        if (cmd_valid_reg && cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end

        // new sample, seeding the goal and clearing the integral on the first one
        if (accept)
        begin
            meas_next = measured_pos;
            tvel_next = target_vel;
            if (first_reg)
            begin
                goal_next = measured_pos;
                esum_next = '0;
            end
        end

        if (cw.diff_en)
        begin
            diff_next = MA_W'(err_reg) - MA_W'(prev_reg);
        end

        case (cw.alu)
            ALU_STEP5:   t_next = sat32(64'(sh5));
            ALU_GOAL:    goal_next = sat32(64'(goal_reg) + 64'(t_reg));
            ALU_ERR:     err_next = sat32(64'(goal_reg) - 64'(meas_reg));
            ALU_ESUM:
            begin
                if (gain_i_reg != '0)
                begin
                    esum_next = sat32(64'(esum_reg) + 64'(sh));
                end
                else
                begin
                    esum_next = '0;
                end
            end
            ALU_ACC_LD:  acc_next = ACC_W'(sat32(64'(sh)));
            ALU_ACC_ADD: acc_next = acc_reg + ACC_W'(sat32(64'(sh)));
            ALU_TSAT:    t_next = sat32(64'(sh));
            ALU_CTRL:    t_next = sat32(64'(acc_reg));
            ALU_OUT:
            begin
                if (!hold)
                begin
                    if (sh > LIM_SH)
                    begin
                        drive_next   = LIM_OUT;
                        clamped_next = 1'b1;
                    end
                    else if (sh < -LIM_SH)
                    begin
                        drive_next   = -LIM_OUT;
                        clamped_next = 1'b1;
                    end
                    else
                    begin
                        drive_next   = sh[VEL_W-1:0];
                        clamped_next = 1'b0;
                    end
                    cmd_valid_next = 1'b1;
                    prev_next      = err_reg;
                    first_next     = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            ts_reg        <= DT_ONE;
            inv_reg       <= DT_ONE;
            goal_reg      <= '0;
            esum_reg      <= '0;
            prev_reg      <= '0;
            first_reg     <= 1'b1;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_P:        gain_p_reg <= cfg_data;
                    REG_GAIN_I:        gain_i_reg <= cfg_data;
                    REG_GAIN_D:        gain_d_reg <= cfg_data;
                    REG_TIME_STEP:     ts_reg     <= cfg_data[DT_W-1:0];
                    REG_INV_TIME_STEP: inv_reg    <= cfg_data[DT_W-1:0];
                    default: ;
                endcase
            end
            goal_reg      <= goal_next;
            esum_reg      <= esum_next;
            prev_reg      <= prev_next;
            first_reg     <= first_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // working registers and output beat payload
    always_ff @(posedge clk)
    begin
        meas_reg    <= meas_next;
        tvel_reg    <= tvel_next;
        err_reg     <= err_next;
        t_reg       <= t_next;
        diff_reg    <= diff_next;
        acc_reg     <= acc_next;
        prod_reg    <= PROD_W'(mul_a) * PROD_W'(mul_b);
        drive_reg   <= drive_next;
        clamped_reg <= clamped_next;
    end

    // checks
    `VPID_ASSERT_NOW(a_clamp_at_limit, cmd_valid && clamped, drive_vel == LIM_OUT || drive_vel == -LIM_OUT, "clamp flag set off the limit")
    `VPID_ASSERT_NOW(a_vel_in_range, cmd_valid, drive_vel <= LIM_OUT && drive_vel >= -LIM_OUT, "command beyond limit")
    `VPID_ASSERT_NEXT(a_start_busy, accept, !sample_ready, "sequencer not started by sample beat")
    `VPID_ASSERT_NEXT(a_first_cleared, out_wr, !first_reg && cmd_valid_reg, "first-step flag or command valid wrong after result")

endmodule

>>> tb/sv/vpid_tb_pkg.sv
// command scoreboard for the velocity pid testbench: register shadow, pid predictor, checks
package vpid_tb_pkg;

    import vpid_pkg::*;

    localparam int  DRIVE_LIMIT = 102944;
    localparam int  Q32_MAX     = 2147483647;
    localparam int  Q32_MIN     = -2147483648;

    // one expected velocity command
    typedef struct {
        logic signed [17:0] vel;
        logic               clamped;
    } drive_cmd_t;

    class pid_cmd_scoreboard;

        // register shadow
        int     kp;
        int     ki;
        int     kd;
        longint dt;
        longint dt_inv;

        // controller state
        int     goal;
        int     esum;
        int     last_err;
        bit     first;

        drive_cmd_t pending_cmds[$];
        int         mismatches;
        int         samples_seen;
        int         cmds_checked;
        int         clamps_seen;

        function new();
            kp = 0;
            ki = 0;
            kd = 0;
            dt = 65536;
            dt_inv = 65536;
            goal = 0;
            esum = 0;
            last_err = 0;
            first = 1;
            mismatches = 0;
            samples_seen = 0;
            cmds_checked = 0;
            clamps_seen = 0;
        endfunction

        // q16.16 product scaling, rounds toward minus infinity
        static function longint floor_q16(longint x);
            return x >>> 16;
        endfunction

        static function int sat_q32(longint x);
            if (x > longint'(Q32_MAX))
            begin
                return Q32_MAX;
            end
            if (x < longint'(Q32_MIN))
            begin
                return Q32_MIN;
            end
            return int'(x);
        endfunction

        // register write, the 31-bit periods keep their low bits only
        function void set_reg(cfg_reg_t idx, logic [31:0] v);
            case (idx)
                REG_GAIN_P:        kp = int'(v);
                REG_GAIN_I:        ki = int'(v);
                REG_GAIN_D:        kd = int'(v);
                REG_TIME_STEP:     dt = longint'(v[30:0]);
                REG_INV_TIME_STEP: dt_inv = longint'(v[30:0]);
                default:           ;
            endcase
        endfunction

        // predicts the command for one accepted sample beat
        function void note_sample(int meas, int tvel);
            longint     pos_inc;
            longint     vel;
            int         err;
            int         pterm;
            int         iterm;
            int         dterm;
            int         dk;
            int         ctrl;
            drive_cmd_t c;
            // seed the target on the very first sample
            if (first)
            begin
                esum = 0;
                goal = meas;
            end
            pos_inc = floor_q16(longint'(tvel) * dt) * 5;
            goal = sat_q32(longint'(goal) + longint'(sat_q32(pos_inc)));
            err = sat_q32(longint'(goal) - longint'(meas));
            pterm = sat_q32(floor_q16(longint'(err) * longint'(kp)));
            // integral held at zero while its gain is zero
            if (ki != 0)
            begin
                esum = sat_q32(longint'(esum) + floor_q16(longint'(err) * dt));
            end
            else
            begin
                esum = 0;
            end
            iterm = sat_q32(floor_q16(longint'(esum) * longint'(ki)));
            // derivative skipped on the first sample
            dterm = 0;
            if (!first)
            begin
                dk = sat_q32(floor_q16((longint'(err) - longint'(last_err)) * longint'(kd)));
                dterm = sat_q32(floor_q16(longint'(dk) * dt_inv));
            end
            last_err = err;
            first = 0;
            ctrl = sat_q32(longint'(pterm) + longint'(iterm) + longint'(dterm));
            vel = floor_q16(longint'(ctrl) * dt_inv);
            c.clamped = 1'b0;
            if (vel > longint'(DRIVE_LIMIT))
            begin
                vel = DRIVE_LIMIT;
                c.clamped = 1'b1;
            end
            else if (vel < -longint'(DRIVE_LIMIT))
            begin
                vel = -DRIVE_LIMIT;
                c.clamped = 1'b1;
            end
            c.vel = 18'(vel);
            pending_cmds.push_back(c);
            samples_seen++;
        endfunction

        // compares one command beat with the oldest prediction
        function void check_command(logic signed [17:0] vel, logic clmp, longint t);
            drive_cmd_t c;
            if (pending_cmds.size() == 0)
            begin
                $display("[%0t] unexpected command: vel %0d clamped %0b", t, vel, clmp);
                mismatches++;
                return;
            end
            c = pending_cmds.pop_front();
            cmds_checked++;
            if (c.clamped)
            begin
                clamps_seen++;
            end
            if (vel !== c.vel)
            begin
                $display("[%0t] drive_vel mismatch: expected %0d actual %0d", t, c.vel, vel);
                mismatches++;
            end
            if (clmp !== c.clamped)
            begin
                $display("[%0t] clamped mismatch: expected %0b actual %0b", t, c.clamped, clmp);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction

    endclass

endpackage

>>> tb/sv/tb_top.sv
// top-level testbench for the velocity pid unit: stimulus, handshakes, watchdog
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import vpid_pkg::*;
    import vpid_tb_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_SAMPLES = 188;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [DATA_W-1:0]          cfg_data;
    logic                       sample_valid;
    logic                       sample_ready;
    logic signed [DATA_W-1:0]   measured_pos;
    logic signed [DATA_W-1:0]   target_vel;
    logic                       cmd_valid;
    logic                       cmd_ready;
    logic signed [VEL_W-1:0]    drive_vel;
    logic                       clamped;

    pid_cmd_scoreboard sb;
    int                stall_cycles;
    int                settings_used;
    int                send_quiet;
    int                recv_quiet;

    velocity_pid_with_position_target_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .measured_pos (measured_pos),
        .target_vel   (target_vel),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .drive_vel    (drive_vel),
        .clamped      (clamped)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle draw with occasional stretches of back-to-back beats
    function automatic int draw_gap(ref int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // gain draw: mostly a few units either side of zero, sometimes extremes
    function automatic logic [31:0] draw_gain();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3:       return $urandom;
            default: return 32'($urandom_range(0, 524288)) - 32'd262144;
        endcase
    endfunction

    // period draw for time_step and its reciprocal
    function automatic logic [31:0] draw_period(int lo, int hi);
        case ($urandom_range(0, 9))
            0:       return 32'd1;
            1:       return 32'h7fff_ffff;
            2:       return {1'b0, 31'($urandom)};
            default: return 32'($urandom_range(lo, hi));
        endcase
    endfunction

    // one register write beat
    task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic write_all(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                             logic [31:0] ts, logic [31:0] inv);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_INV_TIME_STEP, inv);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // waits out every outstanding command, then lets the pipeline settle
    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    // one sample beat, preceded by a random gap
    task automatic send_sample(logic [31:0] meas, logic [31:0] tvel);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        measured_pos <= meas;
        target_vel <= tvel;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ready);
        sb.note_sample(int'(meas), int'(tvel));
    endtask

    // mostly a plant that follows the target, with noise and jumps mixed in
    task automatic run_samples(int n);
        int          reach;
        int          noise;
        logic [31:0] tvel;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_sample($urandom, $urandom);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       reach = 16;
                    1:       reach = 1024;
                    default: reach = 65536;
                endcase
                noise = int'($urandom_range(0, 2 * reach)) - reach;
                tvel = 32'($urandom_range(0, 262144)) - 32'd131072;
                send_sample(32'(sb.goal + noise), tvel);
            end
        end
    endtask

    // command side: random back-pressure, every beat checked
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            stall = draw_gap(recv_quiet);
            if (stall > 0)
            begin
                cmd_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cmd_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!cmd_valid);
            sb.check_command(drive_vel, clamped, $time);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (cmd_valid && cmd_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d commands outstanding", sb.pending());
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // main sequence
    initial
    begin
        sb = new();
        settings_used = 0;
        send_quiet = 0;
        recv_quiet = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_GAIN_P;
        cfg_data <= '0;
        sample_valid <= 1'b0;
        measured_pos <= '0;
        target_vel <= '0;
        cmd_ready <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first sample seeding, field extremes, saturating target
        write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'd655, 32'd6553600);
        send_sample(32'h0001_0000, 32'h0002_0000);
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'h7fff_ffff, 32'h0000_0000);
        send_sample(32'h8000_0000, 32'h0000_0000);
        send_sample(32'h0000_0000, 32'h7fff_ffff);
        send_sample(32'h0000_0000, 32'h7fff_ffff);
        send_sample(32'h0000_0000, 32'h8000_0000);
        send_sample(32'h0000_0000, 32'h8000_0000);
        send_sample(32'hffff_ffff, 32'h0000_0001);
        send_sample(32'h0000_0001, 32'hffff_ffff);
        send_sample(32'(sb.goal), 32'h0001_0000);
        send_sample(32'(sb.goal + 100), 32'h0000_0000);
        send_sample(32'(sb.goal - 100), 32'hffff_0000);
        drain();

        // directed: zero integral gain
        write_all(32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 32'd6554, 32'd655360);
        send_sample(32'(sb.goal + 5000), 32'h0000_1000);
        send_sample(32'(sb.goal - 5000), 32'hffff_f000);
        send_sample(32'h7fff_ffff, 32'h8000_0000);
        send_sample(32'(sb.goal), 32'h0000_0000);
        drain();

        // register settings: all-high extremes, all-low extremes, then random
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h7fff_ffff);
                end
                1:
                begin
                    write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1);
                end
                2:
                begin
                    write_all(draw_gain(), 32'h0000_0000, draw_gain(),
                              draw_period(64, 65536), draw_period(65536, 4194304));
                end
                default:
                begin
                    write_all(draw_gain(), draw_gain(), draw_gain(),
                              draw_period(64, 65536), draw_period(65536, 4194304));
                end
            endcase
            run_samples(PHASE_SAMPLES);
            drain();
        end

        $display("%0d samples over %0d register settings, %0d commands checked (%0d clamped)",
                 sb.samples_seen, settings_used, sb.cmds_checked, sb.clamps_seen);
        $display("%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
